@@ rtl/swsr_pkg.sv @@
`default_nettype none

package swsr_pkg;

	localparam int SEQ_W = 8;
	localparam int POS_W = 32;
	localparam int SUM_W = 24;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 7;

	typedef logic [SEQ_W-1:0] seq_t;
	typedef logic [POS_W-1:0] pos_t;
	typedef logic [SUM_W-1:0] sum_t;
	typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

	// Configuration register indexes.
	localparam cfg_index_t REG_HALF_WINDOW = 2'd0;
	localparam cfg_index_t REG_REPORT_EVERY = 2'd1;

	// Item operation codes.
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	// Control and position of one item on its way from the front end to the merge stage.
	typedef struct packed {
		logic flush;
		logic restart;
		logic do_sub;
		logic eligible;
		logic center_self;
		logic miss;
		seq_t seq;
		pos_t pos;
	} item_t;

endpackage

`default_nettype wire

@@ rtl/swsr_ring.sv @@
`default_nettype none

module swsr_ring #(
	parameter int DEPTH = 256,
	parameter int DW = 16,
	parameter int AW = 8
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/swsr_front.sv @@
`default_nettype none

module swsr_front #(
	parameter int MAX_HALF_WINDOW = 127,
	parameter int COUNT_BITS = 16,
	parameter int AW = 8,
	parameter int HW = 7
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_fire,
	input  wire logic                  op,
	input  wire swsr_pkg::seq_t        seq_id,
	input  wire logic [COUNT_BITS-1:0] cut_count,
	input  wire logic                  is_missing,
	input  wire logic [HW-1:0]         half_window,
	input  wire logic                  restart,
	input  wire logic                  s1_go,
	output logic                       ring_we,
	output logic      [AW-1:0]         ring_waddr,
	output logic      [COUNT_BITS-1:0] cnt_wdata,
	output logic      [AW-1:0]         old_raddr,
	output logic      [AW-1:0]         ctr_raddr,
	output logic                       valid_s1,
	output swsr_pkg::item_t            item_s1,
	output logic      [COUNT_BITS-1:0] cnt_s1
);

	localparam int RING = 2 * MAX_HALF_WINDOW + 2;
	localparam logic [AW:0] RING_V = RING[AW:0];
	localparam logic [AW-1:0] RING_LAST = AW'(RING - 1);

	logic [AW-1:0] ring_wr_q;
	swsr_pkg::pos_t samples_q;
	swsr_pkg::seq_t cur_seq_q;
	logic seq_valid_q;

	logic seq_change, is_sample, overflow, take;
	logic [AW-1:0] wr_use, wr_next;
	swsr_pkg::pos_t samples_use, samples_new, win32, h32;
	logic [HW:0] win;
	logic [AW:0] wr_ext, win_ext, h_ext, old_sum, ctr_sum;
	logic [COUNT_BITS-1:0] cnt_eff;
	swsr_pkg::item_t item_d;

	always_comb begin
		is_sample = (op == swsr_pkg::OP_SAMPLE);
		seq_change = !seq_valid_q || (seq_id != cur_seq_q);
		samples_use = seq_change ? '0 : samples_q;
		wr_use = seq_change ? '0 : ring_wr_q;
		overflow = (samples_use == '1);
		take = !is_sample || !overflow;
		wr_next = (wr_use == RING_LAST) ? '0 : wr_use + 1'b1;
		samples_new = samples_use + 1'b1;
		cnt_eff = is_missing ? '0 : cut_count;

		// Oldest sample leaves the window; center sits half a window back.
		win = {half_window, 1'b1};
		win32 = swsr_pkg::pos_t'(win);
		h32 = swsr_pkg::pos_t'(half_window);
		wr_ext = {1'b0, wr_use};
		win_ext = (AW+1)'(win);
		h_ext = (AW+1)'(half_window);
		old_sum = (wr_ext >= win_ext) ? wr_ext - win_ext : wr_ext + RING_V - win_ext;
		ctr_sum = (wr_ext >= h_ext) ? wr_ext - h_ext : wr_ext + RING_V - h_ext;
		old_raddr = old_sum[AW-1:0];
		ctr_raddr = ctr_sum[AW-1:0];

		ring_we = in_fire && is_sample && !overflow;
		ring_waddr = wr_use;
		cnt_wdata = cnt_eff;

		item_d.flush = !is_sample;
		item_d.restart = (samples_use == '0);
		item_d.do_sub = (samples_use >= win32);
		item_d.eligible = (samples_new >= win32);
		item_d.center_self = (half_window == '0);
		item_d.miss = is_missing;
		item_d.seq = seq_id;
		item_d.pos = samples_new - h32;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_wr_q <= '0;
			samples_q <= '0;
			cur_seq_q <= '0;
			seq_valid_q <= 1'b0;
		end else if (restart) begin
			ring_wr_q <= '0;
			samples_q <= '0;
		end else if (in_fire && is_sample) begin
			cur_seq_q <= seq_id;
			seq_valid_q <= 1'b1;
			if (!overflow) begin
				samples_q <= samples_new;
				ring_wr_q <= wr_next;
			end else begin
				samples_q <= samples_use;
				ring_wr_q <= wr_use;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= take;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1 <= item_d;
			cnt_s1 <= cnt_eff;
		end
	end

endmodule

`default_nettype wire

@@ rtl/swsr_merge.sv @@
`default_nettype none

module swsr_merge #(
	parameter int COUNT_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  valid_s1,
	input  wire swsr_pkg::item_t       item_s1,
	input  wire logic [COUNT_BITS-1:0] cnt_s1,
	input  wire logic [COUNT_BITS-1:0] old_cnt,
	input  wire logic                  mem_miss,
	input  wire logic                  every,
	input  wire logic                  out_ready,
	output logic                       s1_go,
	output logic                       out_valid,
	output swsr_pkg::seq_t             run_seq,
	output swsr_pkg::pos_t             run_first,
	output swsr_pkg::pos_t             run_last,
	output swsr_pkg::sum_t             run_sum
);

	swsr_pkg::sum_t total_q;
	swsr_pkg::seq_t pend_seq_q;
	swsr_pkg::pos_t pend_first_q, pend_last_q;
	swsr_pkg::sum_t pend_sum_q;
	logic pend_valid_q;
	logic out_valid_q;

	swsr_pkg::sum_t base, sub, new_total;
	logic center_miss, report, cont, emit;

	always_comb begin
		base = item_s1.restart ? '0 : total_q;
		sub = item_s1.do_sub ? swsr_pkg::sum_t'(old_cnt) : '0;
		new_total = base - sub + swsr_pkg::sum_t'(cnt_s1);
		center_miss = item_s1.center_self ? item_s1.miss : mem_miss;
		report = !item_s1.flush && item_s1.eligible && (!center_miss || every);
		cont = pend_valid_q && (item_s1.seq == pend_seq_q)
			&& ({1'b0, item_s1.pos} == {1'b0, pend_last_q} + 33'd1)
			&& (new_total == pend_sum_q);
		emit = item_s1.flush ? pend_valid_q : (report && pend_valid_q && !cont);
		s1_go = valid_s1 && (!emit || !out_valid_q || out_ready);
		out_valid = out_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			pend_seq_q <= '0;
			pend_first_q <= '0;
			pend_last_q <= '0;
			pend_sum_q <= '0;
			pend_valid_q <= 1'b0;
		end else if (s1_go) begin
			if (item_s1.flush) begin
				pend_valid_q <= 1'b0;
			end else begin
				total_q <= new_total;
				if (report) begin
					if (!cont) begin
						pend_seq_q <= item_s1.seq;
						pend_first_q <= item_s1.pos - 1'b1;
						pend_sum_q <= new_total;
						pend_valid_q <= 1'b1;
					end
					pend_last_q <= item_s1.pos;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && emit) begin
			run_seq <= pend_seq_q;
			run_first <= pend_first_q;
			run_last <= pend_last_q;
			run_sum <= pend_sum_q;
		end
	end

`ifndef SYNTHESIS
	// A pending run always covers at least one center.
	a_run_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> pend_last_q > pend_first_q)
		else $error("pending run has last not above first");

	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && item_s1.flush |=> !pend_valid_q)
		else $error("flush left a run pending");

	a_emit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && emit |=> out_valid && run_last == $past(pend_last_q))
		else $error("emitted run not loaded into the output register");

	a_report_extends: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && report |=> pend_valid_q && pend_last_q == $past(item_s1.pos))
		else $error("reported center not recorded in the pending run");
`endif

endmodule

`default_nettype wire

@@ rtl/sliding_window_sum_run_merge.sv @@
// Timing: the item that closes a run is registered into the merge stage, and the run
// is then loaded into the output register.
// Throughput: one item per cycle; an item that closes a run stalls only while
// the output register still holds an earlier run that has not been taken.
// Reset: arst_n clears all control and run state at once; the sample ring
// memories are not cleared and are only read at entries written since restart.
`default_nettype none

module sliding_window_sum_run_merge #(
	parameter int MAX_HALF_WINDOW = 127,
	parameter int COUNT_BITS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire swsr_pkg::cfg_index_t         cfg_index,
	input  wire logic [swsr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic                         op,
	input  wire swsr_pkg::seq_t               seq_id,
	input  wire logic [COUNT_BITS-1:0]        cut_count,
	input  wire logic                         is_missing,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output swsr_pkg::seq_t                    run_seq,
	output swsr_pkg::pos_t                    run_first,
	output swsr_pkg::pos_t                    run_last,
	output swsr_pkg::sum_t                    run_sum
);

	// The ring holds one more entry than the widest window, so the sample that
	// leaves the window is never at the address being written in the same cycle.
	localparam int RING = 2 * MAX_HALF_WINDOW + 2;
	localparam int AW = $clog2(RING);
	localparam int HW = $clog2(MAX_HALF_WINDOW + 1);

	logic [HW-1:0] half_q;
	logic every_q;
	logic cfg_fire, restart, in_fire, s1_go, valid_s1;
	logic [swsr_pkg::CFG_DATA_W-1:0] half_raw;

	logic ring_we;
	logic [AW-1:0] ring_waddr, old_raddr, ctr_raddr;
	logic [COUNT_BITS-1:0] cnt_wdata, cnt_s1, old_cnt;
	logic mem_miss;
	swsr_pkg::item_t item_s1;

	// Configuration is always taken. A half window write restarts the
	// current sequence's window at position one; the pending run survives.
	assign cfg_ready = 1'b1;
	assign cfg_fire = cfg_valid && cfg_ready;
	assign restart = cfg_fire && (cfg_index == swsr_pkg::REG_HALF_WINDOW);
	assign half_raw = cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= '0;
			every_q <= 1'b0;
		end else if (cfg_fire) begin
			if (cfg_index == swsr_pkg::REG_HALF_WINDOW) begin
				// Values above the largest supported half window saturate.
				if (32'(half_raw) > 32'(MAX_HALF_WINDOW)) begin
					half_q <= HW'(MAX_HALF_WINDOW);
				end else begin
					half_q <= HW'(half_raw);
				end
			end else if (cfg_index == swsr_pkg::REG_REPORT_EVERY) begin
				every_q <= half_raw[0];
			end
		end
	end

	// The front end takes a new item whenever the merge stage is empty or
	// moving on in this cycle.
	assign in_ready = !valid_s1 || s1_go;
	assign in_fire = in_valid && in_ready;

	swsr_front #(
		.MAX_HALF_WINDOW(MAX_HALF_WINDOW),
		.COUNT_BITS(COUNT_BITS),
		.AW(AW),
		.HW(HW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_fire(in_fire),
		.op(op),
		.seq_id(seq_id),
		.cut_count(cut_count),
		.is_missing(is_missing),
		.half_window(half_q),
		.restart(restart),
		.s1_go(s1_go),
		.ring_we(ring_we),
		.ring_waddr(ring_waddr),
		.cnt_wdata(cnt_wdata),
		.old_raddr(old_raddr),
		.ctr_raddr(ctr_raddr),
		.valid_s1(valid_s1),
		.item_s1(item_s1),
		.cnt_s1(cnt_s1)
	);

	// Counts are read at the sample leaving the window.
	swsr_ring #(
		.DEPTH(RING),
		.DW(COUNT_BITS),
		.AW(AW)
	) u_ring_counts (
		.clk(clk),
		.we(ring_we),
		.waddr(ring_waddr),
		.wdata(cnt_wdata),
		.re(in_fire),
		.raddr(old_raddr),
		.rdata(old_cnt)
	);

	// Missing flags are read at the window center.
	swsr_ring #(
		.DEPTH(RING),
		.DW(1),
		.AW(AW)
	) u_ring_missing (
		.clk(clk),
		.we(ring_we),
		.waddr(ring_waddr),
		.wdata(is_missing),
		.re(in_fire),
		.raddr(ctr_raddr),
		.rdata(mem_miss)
	);

	// Running sum, center reporting and run merging, with the output register.
	swsr_merge #(
		.COUNT_BITS(COUNT_BITS)
	) u_merge (
		.clk(clk),
		.arst_n(arst_n),
		.valid_s1(valid_s1),
		.item_s1(item_s1),
		.cnt_s1(cnt_s1),
		.old_cnt(old_cnt),
		.mem_miss(mem_miss),
		.every(every_q),
		.out_ready(out_ready),
		.s1_go(s1_go),
		.out_valid(out_valid),
		.run_seq(run_seq),
		.run_first(run_first),
		.run_last(run_last),
		.run_sum(run_sum)
	);

endmodule

`default_nettype wire

@@ sim/sliding_window_sum_run_merge_tb.sv @@
module sliding_window_sum_run_merge_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_HALF_WINDOW = 127;
	localparam int COUNT_BITS = 16;
	// The window ring holds 2*H+1 samples plus one spare slot.
	localparam int RING = 2 * MAX_HALF_WINDOW + 2;
	// A run leaves through the merge stage and the output register after the item that closes it; give it some slack.
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_CYCLES = 16;
	// The long receiver hold-off starts once this many items went in.
	localparam int HOLD_AT = 60;
	localparam int HOLD_CYCLES = 400;

	// One input item as the sender offers it.
	typedef struct packed {
		logic op;
		swsr_pkg::seq_t seq;
		logic [COUNT_BITS-1:0] cnt;
		logic miss;
	} bp_item_t;

	// One emitted run: sequence, zero-based start, one-based end, window sum.
	typedef struct packed {
		swsr_pkg::seq_t seq;
		swsr_pkg::pos_t first;
		swsr_pkg::pos_t last;
		swsr_pkg::sum_t sum;
	} run_t;

	typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;
	typedef enum logic {CHECK_MODEL, CHECK_TYPED} check_t;
	typedef enum logic [1:0] {FILL_FLAT, FILL_SPARSE, FILL_STEP, FILL_NOISE} fill_mode_t;

	// A row of the directed table: either a register write or an item. Items
	// with a typed expectation carry the number of runs and the run itself.
	typedef struct packed {
		row_kind_t kind;
		swsr_pkg::cfg_index_t reg_idx;
		logic [swsr_pkg::CFG_DATA_W-1:0] reg_val;
		bp_item_t item;
		check_t how;
		logic exp_n;
		run_t exp_run;
	} row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	swsr_pkg::cfg_index_t cfg_index;
	logic [swsr_pkg::CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic op;
	swsr_pkg::seq_t seq_id;
	logic [COUNT_BITS-1:0] cut_count;
	logic is_missing;
	logic out_valid;
	logic out_ready;
	swsr_pkg::seq_t run_seq;
	swsr_pkg::pos_t run_first;
	swsr_pkg::pos_t run_last;
	swsr_pkg::sum_t run_sum;

	sliding_window_sum_run_merge #(
		.MAX_HALF_WINDOW(MAX_HALF_WINDOW),
		.COUNT_BITS(COUNT_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.seq_id(seq_id),
		.cut_count(cut_count),
		.is_missing(is_missing),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.run_seq(run_seq),
		.run_first(run_first),
		.run_last(run_last),
		.run_sum(run_sum)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Our own copy of the window: sample ring, running sum, position count,
	// current sequence, the run still open, and the two registers.
	logic [COUNT_BITS-1:0] win_counts [RING];
	logic win_absent [RING];
	int unsigned win_wr = 0;
	swsr_pkg::sum_t win_total = '0;
	swsr_pkg::pos_t win_seen = '0;
	swsr_pkg::seq_t win_seq = '0;
	logic win_seq_ok = 1'b0;
	run_t open_run = '0;
	logic open_run_ok = 1'b0;
	int unsigned half_w = 0;
	logic every_pos = 1'b0;

	// Runs the block still owes us, oldest first.
	run_t runs_due [$];
	row_t directed_rows [$];

	int unsigned mismatches = 0;
	int unsigned items_accepted = 0;
	int unsigned send_idle_pct = 9;
	int unsigned recv_idle_pct = 82;
	logic held_off = 1'b0;
	swsr_pkg::seq_t last_seq = '0;

	function automatic void restart_window();
		win_seen = '0;
		win_total = '0;
		win_wr = 0;
	endfunction

	// Advances the window by one accepted item. Returns 1 when the item closes
	// a run, which is then handed back in done_run.
	function automatic logic window_step(input bp_item_t it, output run_t done_run);
		logic emit;
		logic [COUNT_BITS-1:0] c;
		int unsigned w;
		int unsigned idx;
		int unsigned cidx;
		swsr_pkg::pos_t center;
		begin
			emit = 1'b0;
			done_run = open_run;
			if (it.op == swsr_pkg::OP_FLUSH) begin
				// A flush hands out the open run, if there is one, and leaves the
				// window alone.
				emit = open_run_ok;
				open_run_ok = 1'b0;
			end else begin
				// A missing sample counts as zero whatever its count field says.
				c = it.miss ? '0 : it.cnt;
				if (!win_seq_ok || it.seq != win_seq) begin
					win_seq = it.seq;
					win_seq_ok = 1'b1;
					restart_window();
				end
				// Once the position counter is saturated the sequence is frozen.
				if (win_seen != '1) begin
					w = 2 * half_w + 1;
					idx = win_wr;
					if (win_seen >= w)
						win_total = win_total -
							swsr_pkg::sum_t'(win_counts[(idx + RING - w) % RING]);
					win_counts[idx] = c;
					win_absent[idx] = it.miss;
					win_total = win_total + swsr_pkg::sum_t'(c);
					win_seen = win_seen + 1;
					win_wr = (idx + 1) % RING;
					// The window is complete: its center lies half_w positions back.
					if (win_seen >= w) begin
						cidx = (idx + RING - half_w) % RING;
						if (!win_absent[cidx] || every_pos) begin
							center = win_seen - swsr_pkg::pos_t'(half_w);
							if (!open_run_ok || open_run.seq != win_seq ||
								{1'b0, center} != {1'b0, open_run.last} + 33'd1 ||
								win_total != open_run.sum) begin
								emit = open_run_ok;
								done_run = open_run;
								open_run.seq = win_seq;
								open_run.first = center - 1;
								open_run.sum = win_total;
								open_run_ok = 1'b1;
							end
							open_run.last = center;
						end
					end
				end
			end
			window_step = emit;
		end
	endfunction

	// Offers one item, waits for the handshake and books what it should cause.
	task automatic send_item(input bp_item_t it, input check_t how, input logic exp_n,
		input run_t exp_run);
		logic made;
		run_t predicted;
		begin
			while ($urandom_range(99) < send_idle_pct) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
			in_valid <= 1'b1;
			op <= it.op;
			seq_id <= it.seq;
			cut_count <= it.cnt;
			is_missing <= it.miss;
			@(posedge clk);
			while (!in_ready)
				@(posedge clk);
			// The window copy advances on every item, even where the expectation
			// is typed in by hand.
			made = window_step(it, predicted);
			if (how == CHECK_TYPED) begin
				made = exp_n;
				predicted = exp_run;
			end
			if (made)
				runs_due.push_back(predicted);
			items_accepted++;
			// Idling plan: receiver lazy then sender lazy, then nobody idles.
			if (items_accepted < 650) begin
				send_idle_pct = 9;
				recv_idle_pct = 82;
			end else if (items_accepted < 1300) begin
				send_idle_pct = 82;
				recv_idle_pct = 9;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
		end
	endtask

	// Register writes happen only with nothing in flight: every booked run has
	// come out, and a wait of SETTLE_CYCLES lets items that close no run drain.
	task automatic write_reg(input swsr_pkg::cfg_index_t idx,
		input logic [swsr_pkg::CFG_DATA_W-1:0] val);
		begin
			in_valid <= 1'b0;
			while (runs_due.size() != 0)
				@(posedge clk);
			repeat (SETTLE_CYCLES) @(posedge clk);
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data <= val;
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			cfg_valid <= 1'b0;
			if (idx == swsr_pkg::REG_HALF_WINDOW) begin
				half_w = (val > MAX_HALF_WINDOW) ? MAX_HALF_WINDOW : val;
				// A new half width restarts the window; the open run stays.
				restart_window();
			end else if (idx == swsr_pkg::REG_REPORT_EVERY) begin
				every_pos = val[0];
			end
		end
	endtask

	task automatic add_reg(input swsr_pkg::cfg_index_t idx,
		input logic [swsr_pkg::CFG_DATA_W-1:0] val);
		row_t r;
		begin
			r = '0;
			r.kind = ROW_REG;
			r.reg_idx = idx;
			r.reg_val = val;
			directed_rows.push_back(r);
		end
	endtask

	task automatic add_item(input logic o, input swsr_pkg::seq_t s,
		input logic [COUNT_BITS-1:0] c, input logic m, input check_t how, input logic n,
		input swsr_pkg::seq_t rs, input swsr_pkg::pos_t rf, input swsr_pkg::pos_t rl,
		input swsr_pkg::sum_t rsum);
		row_t r;
		begin
			r = '0;
			r.kind = ROW_ITEM;
			r.item.op = o;
			r.item.seq = s;
			r.item.cnt = c;
			r.item.miss = m;
			r.how = how;
			r.exp_n = n;
			r.exp_run.seq = rs;
			r.exp_run.first = rf;
			r.exp_run.last = rl;
			r.exp_run.sum = rsum;
			directed_rows.push_back(r);
		end
	endtask

	// One random sequence of samples. Most sequences are long enough to fill
	// the window; about one in five is at most one window long, mostly too
	// short for any center. The counts follow a fill pattern chosen so that
	// equal sums, and thus merged runs, are common. Stray flushes are added.
	task automatic send_random_sequence(input int unsigned h);
		int unsigned len;
		int unsigned miss_pct;
		int unsigned k;
		fill_mode_t mode;
		logic [COUNT_BITS-1:0] level;
		bp_item_t it;
		bp_item_t stray;
		begin
			it = '0;
			if ($urandom_range(3) == 0)
				it.seq = last_seq;
			else
				it.seq = swsr_pkg::seq_t'($urandom_range(255));
			if ($urandom_range(4) == 0)
				len = $urandom_range(2 * h + 1, 1);
			else
				len = $urandom_range(2 * h + 49, 2 * h + 1);
			mode = fill_mode_t'($urandom_range(3));
			level = ($urandom_range(3) == 0) ? '1 : COUNT_BITS'($urandom);
			case ($urandom_range(2))
				0: miss_pct = 0;
				1: miss_pct = 10;
				default: miss_pct = 45;
			endcase
			for (k = 0; k < len; k++) begin
				if ($urandom_range(99) < 3) begin
					stray = bp_item_t'($bits(bp_item_t)'($urandom));
					stray.op = swsr_pkg::OP_FLUSH;
					send_item(stray, CHECK_MODEL, 1'b0, '0);
				end
				it.op = swsr_pkg::OP_SAMPLE;
				it.miss = ($urandom_range(99) < miss_pct);
				case (mode)
					FILL_FLAT: it.cnt = level;
					FILL_SPARSE: it.cnt = ($urandom_range(5) == 0) ?
						COUNT_BITS'($urandom_range(3, 1)) : '0;
					FILL_STEP: begin
						if ($urandom_range(15) == 0)
							level = COUNT_BITS'($urandom);
						it.cnt = level;
					end
					default: it.cnt = COUNT_BITS'($urandom);
				endcase
				// Missing samples often carry junk counts that must be ignored.
				if (it.miss && $urandom_range(1) == 0)
					it.cnt = COUNT_BITS'($urandom);
				send_item(it, CHECK_MODEL, 1'b0, '0);
			end
			last_seq = it.seq;
		end
	endtask

	task automatic run_phase(input int unsigned h, input logic every, input int unsigned budget);
		int unsigned start;
		begin
			write_reg(swsr_pkg::REG_HALF_WINDOW, swsr_pkg::CFG_DATA_W'(h));
			write_reg(swsr_pkg::REG_REPORT_EVERY, swsr_pkg::CFG_DATA_W'(every));
			start = items_accepted;
			while (items_accepted - start < budget)
				send_random_sequence(h);
		end
	endtask

	function automatic void flag_run(input string what, input run_t want, input run_t got);
		mismatches++;
		if (mismatches <= 10)
			$display({"%0t run %s: expected seq %0d first %0d last %0d sum %0d,",
				" got seq %0d first %0d last %0d sum %0d"},
				$realtime, what, want.seq, want.first, want.last, want.sum,
				got.seq, got.first, got.last, got.sum);
	endfunction

	// Every run taken from the block is compared field by field against the
	// oldest booked run.
	always @(posedge clk) begin : check_runs
		run_t got;
		run_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
			got.seq = run_seq;
			got.first = run_first;
			got.last = run_last;
			got.sum = run_sum;
			if (runs_due.size() == 0) begin
				flag_run("with none expected", '0, got);
			end else begin
				want = runs_due.pop_front();
				if (got.seq !== want.seq || got.first !== want.first ||
					got.last !== want.last || got.sum !== want.sum)
					flag_run("mismatch", want, got);
			end
		end
	end

	// Receiver: takes runs at the random rate of the current idling plan. Once,
	// early in the random part, it refuses runs for a long stretch so that the
	// block fills up and has to push back on its input.
	initial begin : drive_out_ready
		int unsigned hold_left;
		out_ready = 1'b0;
		@(posedge clk);
		while (arst_n !== 1'b1)
			@(posedge clk);
		forever begin
			if (!held_off && items_accepted >= HOLD_AT) begin
				held_off = 1'b1;
				out_ready <= 1'b0;
				for (hold_left = HOLD_CYCLES; hold_left > 0; hold_left--)
					@(posedge clk);
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
			@(posedge clk);
		end
	end

	// Safety net against a hung handshake.
	initial begin : watchdog
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin : stimulus
		bp_item_t flush_item;
		row_t r;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = swsr_pkg::OP_SAMPLE;
		seq_id = '0;
		cut_count = '0;
		is_missing = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = swsr_pkg::REG_HALF_WINDOW;
		cfg_data = '0;

		// Directed table. Out of reset the half width is zero, so each sample
		// is its own window and the sum is just its count.
		// Flush with no open run gives nothing.
		add_item(swsr_pkg::OP_FLUSH, 8'hFF, 16'hFFFF, 1'b1, CHECK_TYPED, 1'b0,
			'0, '0, '0, '0);
		// Two full-scale samples merge into one run over positions 1 and 2.
		add_item(swsr_pkg::OP_SAMPLE, 8'h00, 16'hFFFF, 1'b0, CHECK_TYPED, 1'b0,
			'0, '0, '0, '0);
		add_item(swsr_pkg::OP_SAMPLE, 8'h00, 16'hFFFF, 1'b0, CHECK_TYPED, 1'b0,
			'0, '0, '0, '0);
		// A different sum closes it.
		add_item(swsr_pkg::OP_SAMPLE, 8'h00, 16'h0000, 1'b0, CHECK_TYPED, 1'b1,
			8'h00, 32'd0, 32'd2, 24'hFFFF);
		// A missing sample with a junk count is not reported at all.
		add_item(swsr_pkg::OP_SAMPLE, 8'h00, 16'h1234, 1'b1, CHECK_TYPED, 1'b0,
			'0, '0, '0, '0);
		// Same sum, but the gap at position 4 breaks the run.
		add_item(swsr_pkg::OP_SAMPLE, 8'h00, 16'h0000, 1'b0, CHECK_TYPED, 1'b1,
			8'h00, 32'd2, 32'd3, 24'h0);
		// A new sequence restarts at position 1 and closes the old run.
		add_item(swsr_pkg::OP_SAMPLE, 8'hFF, 16'h0007, 1'b0, CHECK_TYPED, 1'b1,
			8'h00, 32'd4, 32'd5, 24'h0);
		add_item(swsr_pkg::OP_FLUSH, 8'h00, 16'h0000, 1'b0, CHECK_TYPED, 1'b1,
			8'hFF, 32'd0, 32'd1, 24'h7);
		add_item(swsr_pkg::OP_FLUSH, 8'hA5, 16'h5A5A, 1'b1, CHECK_TYPED, 1'b0,
			'0, '0, '0, '0);
		// With every position reported, a missing center shows up with sum zero.
		add_reg(swsr_pkg::REG_REPORT_EVERY, 7'd1);
		add_item(swsr_pkg::OP_SAMPLE, 8'hFF, 16'h0000, 1'b1, CHECK_TYPED, 1'b0,
			'0, '0, '0, '0);
		add_item(swsr_pkg::OP_FLUSH, 8'hFF, 16'hFFFF, 1'b0, CHECK_TYPED, 1'b1,
			8'hFF, 32'd1, 32'd2, 24'h0);
		// Widest window: a three-sample sequence is far too short for a center.
		add_reg(swsr_pkg::REG_HALF_WINDOW, 7'd127);
		add_item(swsr_pkg::OP_SAMPLE, 8'h5A, 16'hFFFF, 1'b0, CHECK_TYPED, 1'b0,
			'0, '0, '0, '0);
		add_item(swsr_pkg::OP_SAMPLE, 8'h5A, 16'hFFFF, 1'b0, CHECK_TYPED, 1'b0,
			'0, '0, '0, '0);
		add_item(swsr_pkg::OP_SAMPLE, 8'h5A, 16'hFFFF, 1'b0, CHECK_TYPED, 1'b0,
			'0, '0, '0, '0);
		add_item(swsr_pkg::OP_FLUSH, 8'h5A, 16'h0000, 1'b0, CHECK_TYPED, 1'b0,
			'0, '0, '0, '0);
		// Half width one, present centers only: counts 1,2,4,1 give the sum 7
		// at centers 2 and 3, one run.
		add_reg(swsr_pkg::REG_HALF_WINDOW, 7'd1);
		add_reg(swsr_pkg::REG_REPORT_EVERY, 7'd0);
		add_item(swsr_pkg::OP_SAMPLE, 8'h5A, 16'h0001, 1'b0, CHECK_TYPED, 1'b0,
			'0, '0, '0, '0);
		add_item(swsr_pkg::OP_SAMPLE, 8'h5A, 16'h0002, 1'b0, CHECK_TYPED, 1'b0,
			'0, '0, '0, '0);
		add_item(swsr_pkg::OP_SAMPLE, 8'h5A, 16'h0004, 1'b0, CHECK_TYPED, 1'b0,
			'0, '0, '0, '0);
		add_item(swsr_pkg::OP_SAMPLE, 8'h5A, 16'h0001, 1'b0, CHECK_TYPED, 1'b0,
			'0, '0, '0, '0);
		add_item(swsr_pkg::OP_FLUSH, 8'h00, 16'h0000, 1'b0, CHECK_TYPED, 1'b1,
			8'h5A, 32'd1, 32'd3, 24'h7);
		// A few more left to the window copy, mid-range counts and a gap.
		add_item(swsr_pkg::OP_SAMPLE, 8'h33, 16'h8000, 1'b0, CHECK_MODEL, 1'b0,
			'0, '0, '0, '0);
		add_item(swsr_pkg::OP_SAMPLE, 8'h33, 16'h7FFF, 1'b0, CHECK_MODEL, 1'b0,
			'0, '0, '0, '0);
		add_item(swsr_pkg::OP_SAMPLE, 8'h33, 16'h8000, 1'b1, CHECK_MODEL, 1'b0,
			'0, '0, '0, '0);
		add_item(swsr_pkg::OP_SAMPLE, 8'h33, 16'h0001, 1'b0, CHECK_MODEL, 1'b0,
			'0, '0, '0, '0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			r = directed_rows[i];
			if (r.kind == ROW_REG)
				write_reg(r.reg_idx, r.reg_val);
			else
				send_item(r.item, r.how, r.exp_n, r.exp_run);
		end

		// Random part: each phase sets both registers, extremes included. A
		// phase runs on to the end of its last sequence, so the budgets leave
		// room for that overshoot.
		run_phase(0, 1'b1, 220);
		run_phase(1, 1'b0, 200);
		run_phase(127, 1'b1, 280);
		run_phase(3, 1'b1, 200);
		run_phase(127, 1'b0, 250);
		run_phase(2, 1'b0, 180);
		run_phase(0, 1'b0, 170);

		// Push out whatever run is still open.
		flush_item = '0;
		flush_item.op = swsr_pkg::OP_FLUSH;
		send_item(flush_item, CHECK_MODEL, 1'b0, '0);
		in_valid <= 1'b0;

		while (runs_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
